// ===== src/fortran_line_literal_tracker_top_defines.svh =====
// Assertion macros used by the line literal tracker RTL.
`ifndef FORTRAN_LINE_LITERAL_TRACKER_TOP_DEFINES_SVH
`define FORTRAN_LINE_LITERAL_TRACKER_TOP_DEFINES_SVH
`ifndef SYNTH
// Same-cycle implication, checked at every rising clock edge out of reset.
`define FLT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("line literal tracker check failed");
// Next-cycle implication, checked at every rising clock edge out of reset.
`define FLT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("line literal tracker check failed");
`else
`define FLT_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define FLT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== src/flt_pkg.sv =====
// Types, character codes and helper functions of the line literal tracker.
package flt_pkg;

	localparam int COUNT_WIDTH      = 16;
	localparam int STATEMENT_COLUMN = 6;
	localparam int COL_W            = $clog2(STATEMENT_COLUMN + 1);

	localparam logic [7:0] CH_AMP    = 8'h26;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_LOW_H  = 8'h68;
	localparam logic [7:0] CH_UP_H   = 8'h48;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_LOW_C  = 8'h63;
	localparam logic [7:0] CH_UP_C   = 8'h43;
	localparam logic [7:0] CH_APOS   = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;

	typedef enum logic [1:0] {
		Q_NONE   = 2'd0,
		Q_APOS   = 2'd1,
		Q_DQUOTE = 2'd2
	} quote_t;

	typedef enum logic [3:0] {
		PH_LINE_START = 4'd0,
		PH_LABEL      = 4'd1,
		PH_COMMENT    = 4'd2,
		PH_FREE_LEAD  = 4'd3,
		PH_LIT_CONT   = 4'd4,
		PH_LIT_CONT_Q = 4'd5,
		PH_HOLL_CONT  = 4'd6,
		PH_SCAN       = 4'd7,
		PH_IN_LIT     = 4'd8,
		PH_LIT_Q      = 4'd9,
		PH_DIGITS     = 4'd10,
		PH_HOLL       = 4'd11,
		PH_DONE       = 4'd12
	} phase_t;

	// Scanner state that lives only within one line.
	typedef struct packed {
		phase_t           phase;
		logic [COL_W-1:0] column;
		quote_t           scan_quote;
		logic             amp;
	} line_ctl_t;

	localparam line_ctl_t LINE_CLEAR = '{
		phase:      PH_LINE_START,
		column:     '0,
		scan_quote: Q_NONE,
		amp:        1'b0
	};

	function automatic logic is_space(logic [7:0] c);
		return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

	function automatic logic is_digit(logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic quote_match(quote_t q, logic [7:0] c);
		logic m;
		unique case (q)
			Q_APOS:   m = (c == CH_APOS);
			Q_DQUOTE: m = (c == CH_DQUOTE);
			default:  m = 1'b0;
		endcase
		return m;
	endfunction

endpackage

// ===== src/flt_in_if.sv =====
// Character input channel: at most one source byte per beat.
interface flt_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] character;
	logic       has_character;
	logic       end_of_line;

	modport source (output valid, output character, output has_character,
		output end_of_line, input ready);
	modport sink (input valid, input character, input has_character,
		input end_of_line, output ready);
endinterface

// ===== src/flt_out_if.sv =====
// Line result channel: the carried lexical state at each line end.
interface flt_out_if #(
	parameter int COUNT_WIDTH = flt_pkg::COUNT_WIDTH
);
	logic                   valid;
	logic                   ready;
	logic [1:0]             open_quote;
	logic [COUNT_WIDTH-1:0] hollerith_left;
	logic                   comment_line;

	modport source (output valid, output open_quote, output hollerith_left,
		output comment_line, input ready);
	modport sink (input valid, input open_quote, input hollerith_left,
		input comment_line, output ready);
endinterface

// ===== src/flt_cfg_if.sv =====
// Configuration write channel carrying the source form register.
interface flt_cfg_if;
	logic valid;
	logic ready;
	logic source_form;

	modport source (output valid, output source_form, input ready);
	modport sink (input valid, input source_form, output ready);
endinterface

// ===== src/flt_scan.sv =====
// Per-byte scanner step: next line state and carried state for one byte.
module flt_scan #(
	parameter int COUNT_WIDTH = flt_pkg::COUNT_WIDTH
) (
	input  logic [7:0]             character,
	input  logic                   has_character,
	input  logic                   fixed,
	input  flt_pkg::line_ctl_t     line_in,
	input  logic [COUNT_WIDTH-1:0] digits_in,
	input  flt_pkg::quote_t        pend_q_in,
	input  logic [COUNT_WIDTH-1:0] pend_h_in,
	output flt_pkg::line_ctl_t     line_out,
	output logic [COUNT_WIDTH-1:0] digits_out,
	output flt_pkg::quote_t        pend_q_out,
	output logic [COUNT_WIDTH-1:0] pend_h_out
);

	logic [COUNT_WIDTH+3:0] dig_wide;
	logic [COUNT_WIDTH-1:0] dig_next;
	logic [COUNT_WIDTH-1:0] holl_dec;
	logic [COUNT_WIDTH-1:0] pend_dec;
	logic                   comment_char;

	// The arithmetic phases are only ever entered on the first pass, so their
	// results can be formed once from the registered values.
	always_comb begin
		dig_wide = ({4'b0, digits_in} << 3) + ({4'b0, digits_in} << 1)
			+ (COUNT_WIDTH + 4)'(character[3:0]);
		dig_next = (|dig_wide[COUNT_WIDTH+3:COUNT_WIDTH]) ? '1 : dig_wide[COUNT_WIDTH-1:0];
		holl_dec = (digits_in == '0) ? '0 : digits_in - COUNT_WIDTH'(1);
		pend_dec = pend_h_in - COUNT_WIDTH'(1);
		comment_char = (character == flt_pkg::CH_LOW_C) || (character == flt_pkg::CH_UP_C)
			|| (character == flt_pkg::CH_STAR) || (character == flt_pkg::CH_BANG);
	end

	always_comb begin : step
		flt_pkg::line_ctl_t     ln;
		logic [COUNT_WIDTH-1:0] dt;
		logic [COUNT_WIDTH-1:0] ph;
		flt_pkg::quote_t        pq;
		logic                   done;
		logic                   at_stmt;

		ln      = line_in;
		dt      = digits_in;
		ph      = pend_h_in;
		pq      = pend_q_in;
		done    = !has_character;
		at_stmt = 1'b0;
		if (has_character && !flt_pkg::is_space(character)) begin
			ln.amp = (character == flt_pkg::CH_AMP);
		end
		// A byte may fall through at most a few phases before it is consumed.
		for (int pass = 0; pass < 4; pass++) begin
			if (!done) begin
				unique case (ln.phase)
					flt_pkg::PH_LINE_START: begin
						if (fixed) begin
							if (comment_char) begin
								ln.phase = flt_pkg::PH_COMMENT;
								done = 1'b1;
							end else begin
								ln.phase  = flt_pkg::PH_LABEL;
								ln.column = '0;
							end
						end else begin
							ln.phase = (pq != flt_pkg::Q_NONE) ? flt_pkg::PH_FREE_LEAD
								: flt_pkg::PH_SCAN;
						end
					end
					flt_pkg::PH_LABEL: begin
						done = 1'b1;
						at_stmt = (ln.column >= flt_pkg::COL_W'(flt_pkg::STATEMENT_COLUMN - 1));
						if (ln.column < flt_pkg::COL_W'(flt_pkg::STATEMENT_COLUMN)) begin
							ln.column = ln.column + flt_pkg::COL_W'(1);
						end
						if (at_stmt) begin
							if ((pq != flt_pkg::Q_NONE) || (ph != '0)) begin
								if ((character != flt_pkg::CH_SPACE)
									&& (character != flt_pkg::CH_ZERO)) begin
									ln.phase = (ph != '0) ? flt_pkg::PH_HOLL_CONT
										: flt_pkg::PH_LIT_CONT;
								end else begin
									pq = flt_pkg::Q_NONE;
									ph = '0;
									ln.phase = flt_pkg::PH_SCAN;
								end
							end else begin
								ln.phase = flt_pkg::PH_SCAN;
							end
						end
					end
					flt_pkg::PH_COMMENT, flt_pkg::PH_DONE: begin
						done = 1'b1;
					end
					flt_pkg::PH_FREE_LEAD: begin
						if (flt_pkg::is_space(character)) begin
							done = 1'b1;
						end else begin
							ln.phase = flt_pkg::PH_LIT_CONT;
							if (character == flt_pkg::CH_AMP) begin
								done = 1'b1;
							end
						end
					end
					flt_pkg::PH_LIT_CONT: begin
						done = 1'b1;
						if (flt_pkg::quote_match(pq, character)) begin
							ln.phase = flt_pkg::PH_LIT_CONT_Q;
						end
					end
					flt_pkg::PH_LIT_CONT_Q: begin
						if (flt_pkg::quote_match(pq, character)) begin
							ln.phase = flt_pkg::PH_LIT_CONT;
							done = 1'b1;
						end else begin
							pq = flt_pkg::Q_NONE;
							ln.phase = flt_pkg::PH_SCAN;
						end
					end
					flt_pkg::PH_HOLL_CONT: begin
						if (ph != '0) begin
							ph = pend_dec;
							if (pend_dec == '0) begin
								ln.phase = flt_pkg::PH_SCAN;
							end
							done = 1'b1;
						end else begin
							ln.phase = flt_pkg::PH_SCAN;
						end
					end
					flt_pkg::PH_SCAN: begin
						done = 1'b1;
						if (character == flt_pkg::CH_BANG) begin
							ln.phase = flt_pkg::PH_DONE;
						end else if (character == flt_pkg::CH_APOS) begin
							ln.scan_quote = flt_pkg::Q_APOS;
							ln.phase = flt_pkg::PH_IN_LIT;
						end else if (character == flt_pkg::CH_DQUOTE) begin
							ln.scan_quote = flt_pkg::Q_DQUOTE;
							ln.phase = flt_pkg::PH_IN_LIT;
						end else if (flt_pkg::is_digit(character)) begin
							dt = COUNT_WIDTH'(character[3:0]);
							ln.phase = flt_pkg::PH_DIGITS;
						end
					end
					flt_pkg::PH_IN_LIT: begin
						done = 1'b1;
						if (flt_pkg::quote_match(ln.scan_quote, character)) begin
							ln.phase = flt_pkg::PH_LIT_Q;
						end
					end
					flt_pkg::PH_LIT_Q: begin
						if (flt_pkg::quote_match(ln.scan_quote, character)) begin
							ln.phase = flt_pkg::PH_IN_LIT;
							done = 1'b1;
						end else begin
							ln.phase = flt_pkg::PH_SCAN;
						end
					end
					flt_pkg::PH_DIGITS: begin
						if (flt_pkg::is_digit(character)) begin
							dt = dig_next;
							done = 1'b1;
						end else if ((character == flt_pkg::CH_LOW_H)
							|| (character == flt_pkg::CH_UP_H)) begin
							ln.phase = (dt == '0) ? flt_pkg::PH_SCAN : flt_pkg::PH_HOLL;
							done = 1'b1;
						end else begin
							ln.phase = flt_pkg::PH_SCAN;
						end
					end
					flt_pkg::PH_HOLL: begin
						dt = holl_dec;
						if (holl_dec == '0) begin
							ln.phase = flt_pkg::PH_SCAN;
						end
						done = 1'b1;
					end
					default: begin
						ln.phase = flt_pkg::PH_SCAN;
					end
				endcase
			end
		end
		line_out   = ln;
		digits_out = dt;
		pend_q_out = pq;
		pend_h_out = ph;
	end

endmodule

// ===== src/flt_line_end.sv =====
// Line-end resolution of the carried state and the registered result beat.
module flt_line_end #(
	parameter int COUNT_WIDTH = flt_pkg::COUNT_WIDTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   fixed,
	input  flt_pkg::line_ctl_t     line_in,
	input  logic [COUNT_WIDTH-1:0] digits_in,
	input  flt_pkg::quote_t        pend_q_in,
	input  logic [COUNT_WIDTH-1:0] pend_h_in,
	input  logic                   load,
	output logic                   room,
	output flt_pkg::quote_t        pend_q_out,
	output logic [COUNT_WIDTH-1:0] pend_h_out,
	flt_out_if.source              result
);

	logic                   comment;
	logic                   valid_q;
	logic [1:0]             quote_q;
	logic [COUNT_WIDTH-1:0] holl_q;
	logic                   comment_q;

	always_comb begin
		pend_q_out = pend_q_in;
		pend_h_out = pend_h_in;
		comment    = 1'b0;
		unique case (line_in.phase)
			flt_pkg::PH_COMMENT: begin
				comment = 1'b1;
			end
			flt_pkg::PH_HOLL_CONT: begin
				pend_q_out = pend_q_in;
			end
			flt_pkg::PH_LIT_CONT, flt_pkg::PH_FREE_LEAD: begin
				if (!fixed && !line_in.amp) begin
					pend_q_out = flt_pkg::Q_NONE;
				end
			end
			flt_pkg::PH_IN_LIT: begin
				if (fixed) begin
					pend_q_out = line_in.scan_quote;
					pend_h_out = '0;
				end else begin
					pend_q_out = line_in.amp ? line_in.scan_quote : flt_pkg::Q_NONE;
				end
			end
			flt_pkg::PH_HOLL: begin
				pend_q_out = flt_pkg::Q_NONE;
				if (fixed) begin
					pend_h_out = digits_in;
				end
			end
			default: begin
				pend_q_out = flt_pkg::Q_NONE;
				if (fixed) begin
					pend_h_out = '0;
				end
			end
		endcase
	end

	assign room = !valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (result.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			quote_q   <= pend_q_out;
			holl_q    <= pend_h_out;
			comment_q <= comment;
		end
	end

	assign result.valid          = valid_q;
	assign result.open_quote     = quote_q;
	assign result.hollerith_left = holl_q;
	assign result.comment_line   = comment_q;

endmodule

// ===== src/fortran_line_literal_tracker_top.sv =====
// Top level of the Fortran line literal tracker.
// The tracker takes Fortran source as a stream of byte beats on the chars channel,
// each beat holding one byte (or none, for an empty line) and a flag that closes
// the line, and for every beat that closes a line it returns one result beat with
// the lexical state carried into the next line: an open character literal and
// its quote kind, the Hollerith characters still owed (saturated at the top of
// the count width), and whether the line was a fixed-form comment line. Beats
// that do not close a line produce no result. The source_form register selects
// free form (0) or fixed form (1); it resets to free form and is written through
// the cfg channel, which is always ready, and should only be written while no
// beat is in flight. The block sustains one byte beat per clock cycle unless stalled:
// a byte is captured in an input register, and from there a single pass of
// combinational logic advances the scanner state and, at a line end, loads the
// result register, from which the result beat is presented. The rate is set by
// the scanner state update, which every byte needs before the next one can be
// scanned. The result register decouples the two sides: new bytes keep flowing
// while a result waits, and only a second line end that finds the result
// register still full stalls the input.
`include "fortran_line_literal_tracker_top_defines.svh"

module fortran_line_literal_tracker_top #(
	parameter int COUNT_WIDTH = flt_pkg::COUNT_WIDTH
) (
	input  logic       clk,
	input  logic       arst_n,
	flt_in_if.sink     chars,
	flt_out_if.source  result,
	flt_cfg_if.sink    cfg
);

	// Input register stage.
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       has_s1;
	logic       eol_s1;

	// Scanner state: line-local control, digit run, carried literal state.
	flt_pkg::line_ctl_t     line_q;
	logic [COUNT_WIDTH-1:0] digits_q;
	flt_pkg::quote_t        pend_q_q;
	logic [COUNT_WIDTH-1:0] pend_h_q;
	logic                   form_q;

	flt_pkg::line_ctl_t     line_nx;
	logic [COUNT_WIDTH-1:0] digits_nx;
	flt_pkg::quote_t        pend_q_nx;
	logic [COUNT_WIDTH-1:0] pend_h_nx;
	flt_pkg::quote_t        pend_q_end;
	logic [COUNT_WIDTH-1:0] pend_h_end;

	logic room;
	logic adv;
	logic load;

	// A byte in the input register moves on unless it closes a line and the
	// result register cannot take the new result.
	assign adv         = valid_s1 && (!eol_s1 || room);
	assign load        = adv && eol_s1;
	assign chars.ready = !valid_s1 || adv;
	assign cfg.ready   = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			form_q <= 1'b0;
		end else if (cfg.valid) begin
			form_q <= cfg.source_form;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.valid && chars.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			char_s1 <= chars.character;
			has_s1  <= chars.has_character;
			eol_s1  <= chars.end_of_line;
		end
	end

	flt_scan #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_scan (
		.character    (char_s1),
		.has_character(has_s1),
		.fixed        (form_q),
		.line_in      (line_q),
		.digits_in    (digits_q),
		.pend_q_in    (pend_q_q),
		.pend_h_in    (pend_h_q),
		.line_out     (line_nx),
		.digits_out   (digits_nx),
		.pend_q_out   (pend_q_nx),
		.pend_h_out   (pend_h_nx)
	);

	flt_line_end #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_line_end (
		.clk       (clk),
		.arst_n    (arst_n),
		.fixed     (form_q),
		.line_in   (line_nx),
		.digits_in (digits_nx),
		.pend_q_in (pend_q_nx),
		.pend_h_in (pend_h_nx),
		.load      (load),
		.room      (room),
		.pend_q_out(pend_q_end),
		.pend_h_out(pend_h_end),
		.result    (result)
	);

	// At a line end the line-local state starts over and the resolved carried
	// state is kept; otherwise the scanner step is taken as it stands.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q   <= flt_pkg::LINE_CLEAR;
			digits_q <= '0;
			pend_q_q <= flt_pkg::Q_NONE;
			pend_h_q <= '0;
		end else if (adv) begin
			if (eol_s1) begin
				line_q   <= flt_pkg::LINE_CLEAR;
				digits_q <= '0;
				pend_q_q <= pend_q_end;
				pend_h_q <= pend_h_end;
			end else begin
				line_q   <= line_nx;
				digits_q <= digits_nx;
				pend_q_q <= pend_q_nx;
				pend_h_q <= pend_h_nx;
			end
		end
	end

	// A line end that moves on always shows up as a result beat.
	`FLT_ASSERT_NEXT(a_result_loaded, clk, arst_n, load, result.valid)
	// Every line starts over from the line start phase.
	`FLT_ASSERT_NEXT(a_line_restart, clk, arst_n, load, line_q.phase == flt_pkg::PH_LINE_START)
	// A line end held back by a full result register leaves the carried state alone.
	`FLT_ASSERT_NEXT(a_stall_holds, clk, arst_n, valid_s1 && eol_s1 && !room, $stable(pend_q_q) && $stable(pend_h_q))
	// The label column counter never runs past the statement column.
	`FLT_ASSERT_IMPL(a_column_bound, clk, arst_n, 1'b1, line_q.column <= flt_pkg::COL_W'(flt_pkg::STATEMENT_COLUMN))

endmodule
